FILE: hdl/kfpv_pkg.sv
`timescale 1ns / 1ps
package kfpv_pkg;
    localparam int WORD_WIDTH = 48;
    localparam int FRAC_BITS = 16;
    localparam int VAR_WIDTH = 47;
    localparam int DT_WIDTH = 25;
    localparam int ACC_WIDTH = 32;
    localparam int CFG_WIDTH = 48;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int MUL_WIDTH = 2 * WORD_WIDTH + 2;
    localparam int GAIN_STEPS = FRAC_BITS + 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCELERATION = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_POSITION = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_VELOCITY = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_POS_VAR = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_VEL_VAR = 3'd5;

    localparam logic signed [WORD_WIDTH-1:0] MAXW = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [WORD_WIDTH-1:0] MINW = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam logic signed [WORD_WIDTH-1:0] ONE_Q =
        WORD_WIDTH'(64'sd1 <<< FRAC_BITS);

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] measured_position;
        logic signed [WORD_WIDTH-1:0] measured_velocity;
        logic [VAR_WIDTH-1:0]         measured_position_variance;
        logic [VAR_WIDTH-1:0]         measured_velocity_variance;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] estimated_position;
        logic signed [WORD_WIDTH-1:0] estimated_velocity;
        logic [VAR_WIDTH-1:0]         estimated_position_variance;
        logic [VAR_WIDTH-1:0]         estimated_velocity_variance;
    } out_item_t;

    // lane handshake between sequencer and gain lanes
    typedef struct packed {
        logic start;
        logic busy;
    } lane_ctl_t;

    function automatic logic signed [WORD_WIDTH-1:0] sat_add(
        input logic signed [WORD_WIDTH-1:0] a,
        input logic signed [WORD_WIDTH-1:0] b);
        logic signed [WORD_WIDTH:0] s;
        s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
        if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
            return s[WORD_WIDTH] ? MINW : MAXW;
        return s[WORD_WIDTH-1:0];
    endfunction

    // a - b formed one bit wider, so the most negative b saturates cleanly
    function automatic logic signed [WORD_WIDTH-1:0] sat_sub(
        input logic signed [WORD_WIDTH-1:0] a,
        input logic signed [WORD_WIDTH-1:0] b);
        logic signed [WORD_WIDTH:0] s;
        s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
        if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
            return s[WORD_WIDTH] ? MINW : MAXW;
        return s[WORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] clamp_var(
        input logic signed [WORD_WIDTH-1:0] v);
        return v[WORD_WIDTH-1] ? '0 : v;
    endfunction

    // round(p / 2^(FRAC_BITS + half)), ties up, saturated to the word range
    function automatic logic signed [WORD_WIDTH-1:0] round_sat(
        input logic signed [MUL_WIDTH-1:0] p,
        input logic                        half);
        logic signed [MUL_WIDTH-1:0] r;
        if (half)
            r = (p + (MUL_WIDTH'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
        else
            r = (p + (MUL_WIDTH'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > MUL_WIDTH'(MAXW)) return MAXW;
        if (r < MUL_WIDTH'(MINW)) return MINW;
        return r[WORD_WIDTH-1:0];
    endfunction
endpackage

FILE: hdl/kfpv_mul.sv
`timescale 1ns / 1ps
module kfpv_mul import kfpv_pkg::*; (
    input  logic                         aclk,
    input  logic signed [WORD_WIDTH-1:0] a,
    input  logic signed [WORD_WIDTH-1:0] b,
    input  logic                         half,
    output logic signed [WORD_WIDTH-1:0] y
);
    // 48x48 split into 24-bit partial products, one register between
    localparam int HW = WORD_WIDTH / 2;
    logic [WORD_WIDTH-1:0] ua, ub;
    logic [2*HW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic neg_reg, half_reg;
    logic [2*WORD_WIDTH-1:0] mag;
    logic signed [MUL_WIDTH-1:0] prod;

    assign ua = a[WORD_WIDTH-1] ? WORD_WIDTH'(-a) : a;
    assign ub = b[WORD_WIDTH-1] ? WORD_WIDTH'(-b) : b;

    always_ff @(posedge aclk) begin
        p00_reg  <= ua[HW-1:0] * ub[HW-1:0];
        p01_reg  <= ua[HW-1:0] * ub[WORD_WIDTH-1:HW];
        p10_reg  <= ua[WORD_WIDTH-1:HW] * ub[HW-1:0];
        p11_reg  <= ua[WORD_WIDTH-1:HW] * ub[WORD_WIDTH-1:HW];
        neg_reg  <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
        half_reg <= half;
    end

    always_comb begin
        mag = {p11_reg, p00_reg} + ({(2*WORD_WIDTH)'(p01_reg)} << HW)
            + ({(2*WORD_WIDTH)'(p10_reg)} << HW);
        prod = neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        y = round_sat(prod, half_reg);
    end
endmodule

FILE: hdl/kfpv_gain_lane.sv
`timescale 1ns / 1ps
module kfpv_gain_lane import kfpv_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lane_ctl_t                    ctl_in,
    input  logic signed [WORD_WIDTH-1:0] p,
    input  logic signed [WORD_WIDTH-1:0] r,
    output logic                         busy,
    output logic signed [WORD_WIDTH-1:0] k
);
    // restoring divider, one quotient bit a cycle
    logic [WORD_WIDTH:0]   d_reg, rem_reg;
    logic [FRAC_BITS-1:0]  q_reg;
    logic [4:0]            cnt_reg;
    logic                  run_reg;
    logic [WORD_WIDTH+1:0] sh;
    logic [WORD_WIDTH:0]   d_w;

    assign d_w = {1'b0, p} + {1'b0, r};
    assign sh = {rem_reg, 1'b0};
    assign busy = run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (ctl_in.start) begin
            d_reg   <= d_w;
            rem_reg <= {1'b0, p};
            q_reg   <= '0;
            cnt_reg <= '0;
            if (d_w == '0) begin
                run_reg <= 1'b0;
                k <= '0;
            end else if ({1'b0, p} >= d_w) begin
                run_reg <= 1'b0;
                k <= ONE_Q;
            end else begin
                run_reg <= 1'b1;
            end
        end else if (run_reg) begin
            if (sh >= {1'b0, d_reg}) begin
                rem_reg <= (WORD_WIDTH+1)'(sh - {1'b0, d_reg});
                q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= sh[WORD_WIDTH:0];
                q_reg   <= {q_reg[FRAC_BITS-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(GAIN_STEPS - 1)) begin
                run_reg <= 1'b0;
                k <= WORD_WIDTH'((({q_reg, (sh >= {1'b0, d_reg})}) + 1) >> 1);
            end
        end
    end
endmodule

FILE: hdl/kalman_filter_position_velocity_unit.sv
`timescale 1ns / 1ps
// Position/velocity Kalman filter with diagonal covariance.
// Input channel s_*: one measurement (position, velocity and their
// variances) per transfer. Output channel m_*: one estimate per input.
// Config port: cfg_we/cfg_index/cfg_data write a register; a write to a
// valid index reloads the kept state from the four init registers. Write
// only while nothing is in flight; other indexes are ignored.
// Each item runs through a sequencer that shares one two-stage multiplier;
// the position and velocity gains come from two parallel lanes, each a
// restoring divider producing one quotient bit a cycle, and a merge step
// applies both corrections. After the s_valid transfer an item passes
// through five predict multiplies, the divider lanes (17 steps plus start
// and collect), the corrections and the output load; the divider steps are
// skipped when neither gain needs a division (zero denominator or zero
// measurement variance). One item is in flight at a time; s_ready returns
// as the result is loaded, so the next transfer waits for that load.
// Reset (aresetn low, synchronous) idles the sequencer, clears m_valid,
// restores the config registers and loads the state from them. When m_ready
// is low the result holds in the output register; the next item is still
// taken and waits in its last step until the output register is free.
module kalman_filter_position_velocity_unit import kfpv_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_data,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_M1    = 9'b000000010,
        ST_M2    = 9'b000000100,
        ST_M3    = 9'b000001000,
        ST_M4    = 9'b000010000,
        ST_M5    = 9'b000100000,
        ST_GAIN  = 9'b001000000,
        ST_CORR  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    logic [2:0] sub_reg;

    logic [DT_WIDTH-1:0]          dt_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [WORD_WIDTH-1:0] ipos_reg, ivel_reg;
    logic [VAR_WIDTH-1:0]         ipv_reg, ivv_reg;
    logic signed [WORD_WIDTH-1:0] pos_reg, vel_reg, pv_reg, vv_reg;
    logic signed [WORD_WIDTH-1:0] z0_reg, z1_reg, r0_reg, r1_reg;
    logic signed [WORD_WIDTH-1:0] dt2_reg, x0_reg, x1_reg, p0_reg, p1_reg;
    logic signed [WORD_WIDTH-1:0] k0_reg, k1_reg;

    logic signed [WORD_WIDTH-1:0] ma, mb, my, my_var;
    logic mhalf;
    lane_ctl_t lctl;
    logic busy0, busy1;
    logic signed [WORD_WIDTH-1:0] k0, k1;
    out_item_t out_reg;
    logic out_valid_reg;
    logic out_free;
    logic cfg_hit;

    kfpv_mul u_mul (.aclk(aclk), .a(ma), .b(mb), .half(mhalf), .y(my));

    kfpv_gain_lane u_lane0 (.aclk(aclk), .aresetn(aresetn), .ctl_in(lctl),
        .p(p0_reg), .r(r0_reg), .busy(busy0), .k(k0));
    kfpv_gain_lane u_lane1 (.aclk(aclk), .aresetn(aresetn), .ctl_in(lctl),
        .p(vv_reg), .r(r1_reg), .busy(busy1), .k(k1));

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign cfg_hit  = cfg_we && (cfg_index <= REG_INIT_VEL_VAR);
    assign my_var   = clamp_var(my);

    // operand select for the shared multiplier per step
    always_comb begin
        ma = '0;
        mb = '0;
        mhalf = 1'b0;
        lctl.start = (state_reg == ST_GAIN) && (sub_reg == 3'd0);
        lctl.busy = busy0 | busy1;
        unique case (state_reg)
            ST_M1: begin ma = WORD_WIDTH'(dt_reg); mb = WORD_WIDTH'(dt_reg); end
            ST_M2: begin ma = WORD_WIDTH'(dt_reg); mb = vel_reg; end
            ST_M3: begin ma = WORD_WIDTH'(acc_reg); mb = dt2_reg; mhalf = 1'b1; end
            ST_M4: begin ma = WORD_WIDTH'(acc_reg); mb = WORD_WIDTH'(dt_reg); end
            ST_M5: begin ma = dt2_reg; mb = vv_reg; end
            ST_CORR: begin
                unique case (sub_reg)
                    3'd0: begin ma = k0_reg; mb = sat_sub(z0_reg, x0_reg); end
                    3'd1: begin ma = k1_reg; mb = sat_sub(z1_reg, x1_reg); end
                    3'd2: begin ma = ONE_Q - k0_reg; mb = p0_reg; end
                    default: begin ma = ONE_Q - k1_reg; mb = vv_reg; end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sub_reg <= '0;
            out_valid_reg <= 1'b0;
            dt_reg  <= DT_WIDTH'(65536);
            acc_reg <= ACC_WIDTH'(131072);
            ipos_reg <= WORD_WIDTH'(262144000);
            ivel_reg <= WORD_WIDTH'(18350080);
            ipv_reg <= VAR_WIDTH'(26214400);
            ivv_reg <= VAR_WIDTH'(1638400);
            pos_reg <= WORD_WIDTH'(262144000);
            vel_reg <= WORD_WIDTH'(18350080);
            pv_reg  <= WORD_WIDTH'(26214400);
            vv_reg  <= WORD_WIDTH'(1638400);
        end else begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_valid && m_ready)
                out_valid_reg <= 1'b0;
            if (cfg_hit) begin
                // reload the state, taking the value being written where it lands
                pos_reg <= (cfg_index == REG_INIT_POSITION) ? $signed(cfg_data) : ipos_reg;
                vel_reg <= (cfg_index == REG_INIT_VELOCITY) ? $signed(cfg_data) : ivel_reg;
                pv_reg  <= WORD_WIDTH'((cfg_index == REG_INIT_POS_VAR) ?
                    cfg_data[VAR_WIDTH-1:0] : ipv_reg);
                vv_reg  <= WORD_WIDTH'((cfg_index == REG_INIT_VEL_VAR) ?
                    cfg_data[VAR_WIDTH-1:0] : ivv_reg);
                unique case (cfg_index)
                    REG_TIME_STEP: dt_reg <= cfg_data[DT_WIDTH-1:0];
                    REG_ACCELERATION: acc_reg <= cfg_data[ACC_WIDTH-1:0];
                    REG_INIT_POSITION: ipos_reg <= cfg_data;
                    REG_INIT_VELOCITY: ivel_reg <= cfg_data;
                    REG_INIT_POS_VAR: ipv_reg <= cfg_data[VAR_WIDTH-1:0];
                    REG_INIT_VEL_VAR: ivv_reg <= cfg_data[VAR_WIDTH-1:0];
                    default: ;
                endcase
            end
            // each multiply step: issue at sub 0, result at sub 1
            unique case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    z0_reg <= s_data.measured_position;
                    z1_reg <= s_data.measured_velocity;
                    r0_reg <= WORD_WIDTH'(s_data.measured_position_variance);
                    r1_reg <= WORD_WIDTH'(s_data.measured_velocity_variance);
                    sub_reg <= '0;
                    state_reg <= ST_M1;
                end
                ST_M1: if (sub_reg == 3'd1) begin
                    dt2_reg <= my; sub_reg <= '0; state_reg <= ST_M2;
                end else begin
                    sub_reg <= 3'd1;
                end
                ST_M2: if (sub_reg == 3'd1) begin
                    x0_reg <= sat_add(pos_reg, my); sub_reg <= '0;
                    state_reg <= ST_M3;
                end else begin
                    sub_reg <= 3'd1;
                end
                ST_M3: if (sub_reg == 3'd1) begin
                    x0_reg <= sat_add(x0_reg, my); sub_reg <= '0;
                    state_reg <= ST_M4;
                end else begin
                    sub_reg <= 3'd1;
                end
                ST_M4: if (sub_reg == 3'd1) begin
                    x1_reg <= sat_add(vel_reg, my); sub_reg <= '0;
                    state_reg <= ST_M5;
                end else begin
                    sub_reg <= 3'd1;
                end
                ST_M5: if (sub_reg == 3'd1) begin
                    p0_reg <= clamp_var(sat_add(pv_reg, my)); sub_reg <= '0;
                    state_reg <= ST_GAIN;
                end else begin
                    sub_reg <= 3'd1;
                end
                ST_GAIN: begin
                    if (sub_reg == 3'd0)
                        sub_reg <= 3'd1;
                    else if (sub_reg == 3'd1)
                        sub_reg <= 3'd2;
                    else if (!lctl.busy) begin
                        k0_reg <= k0; k1_reg <= k1;
                        sub_reg <= '0; state_reg <= ST_CORR;
                    end
                end
                ST_CORR: begin
                    // pipelined: issue at sub n, collect at sub n+1
                    sub_reg <= sub_reg + 3'd1;
                    unique case (sub_reg)
                        3'd1: x0_reg <= sat_add(x0_reg, my);
                        3'd2: x1_reg <= sat_add(x1_reg, my);
                        3'd3: p0_reg <= my_var;
                        3'd4: begin
                            p1_reg <= my_var;
                            state_reg <= ST_OUT;
                        end
                        default: ;
                    endcase
                end
                // hold here while the previous result still waits
                ST_OUT: if (out_free) begin
                    out_reg.estimated_position <= x0_reg;
                    out_reg.estimated_velocity <= x1_reg;
                    out_reg.estimated_position_variance <= p0_reg[VAR_WIDTH-1:0];
                    out_reg.estimated_velocity_variance <= p1_reg[VAR_WIDTH-1:0];
                    pos_reg <= x0_reg;
                    vel_reg <= x1_reg;
                    pv_reg  <= p0_reg;
                    vv_reg  <= p1_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/kfpv_checker.sv
`timescale 1ns / 1ps
module kfpv_checker import kfpv_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    // the shortest pass through the sequencer keeps the input closed this long
    a_in_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready [*19])
        else $error("input taken while an item is in flight");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");
endmodule

bind kalman_filter_position_velocity_unit kfpv_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

FILE: test/kalman_filter_position_velocity_unit_tb.sv
`timescale 1ns / 1ps
module kalman_filter_position_velocity_unit_tb;
    import kfpv_pkg::*;

    localparam longint POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_MIN = -POS_MAX - 1;
    localparam longint VAR_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    kalman_filter_position_velocity_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // filter state and registers as the block should hold them
    longint unsigned filt_reg [6];
    longint est_pos, est_vel, est_pos_var, est_vel_var;
    out_item_t estimates_due [$];

    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    function automatic longint clamp_word(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic longint clamp_variance(longint v);
        v = clamp_word(v);
        return (v < 0) ? 0 : v;
    endfunction

    function automatic longint scaled_product(longint a, longint b, int sh);
        logic signed [127:0] p;
        p = a;
        p = p * b;
        p = (p + (128'sd1 <<< (sh - 1))) >>> sh;
        if (p > POS_MAX) return POS_MAX;
        if (p < POS_MIN) return POS_MIN;
        return longint'(p[63:0]);
    endfunction

    function automatic longint kalman_gain(longint p, longint r);
        longint unsigned d, rem, q;
        d = p + r;
        rem = p;
        q = 0;
        if (d == 0) return 0;
        if (rem >= d) return Q_ONE;
        for (int i = 0; i < FRAC_BITS + 1; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q = q | 1;
            end
        end
        return longint'((q + 1) >> 1);
    endfunction

    function automatic void reload_estimates();
        logic signed [47:0] w;
        w = filt_reg[REG_INIT_POSITION][47:0];
        est_pos = w;
        w = filt_reg[REG_INIT_VELOCITY][47:0];
        est_vel = w;
        est_pos_var = clamp_variance(longint'(filt_reg[REG_INIT_POS_VAR][46:0]));
        est_vel_var = clamp_variance(longint'(filt_reg[REG_INIT_VEL_VAR][46:0]));
    endfunction

    function automatic out_item_t filter_update(in_item_t m);
        longint dt, acc, dt2, x0, x1, p0, p1, k0, k1, z0, z1, r0, r1;
        int a32;
        out_item_t o;
        dt = longint'(filt_reg[REG_TIME_STEP][24:0]);
        a32 = filt_reg[REG_ACCELERATION][31:0];
        acc = a32;
        z0 = m.measured_position;
        z1 = m.measured_velocity;
        r0 = longint'(m.measured_position_variance);
        r1 = longint'(m.measured_velocity_variance);
        dt2 = scaled_product(dt, dt, FRAC_BITS);
        x0 = clamp_word(est_pos + scaled_product(dt, est_vel, FRAC_BITS));
        x0 = clamp_word(x0 + scaled_product(acc, dt2, FRAC_BITS + 1));
        x1 = clamp_word(est_vel + scaled_product(acc, dt, FRAC_BITS));
        p0 = clamp_variance(est_pos_var + scaled_product(dt2, est_vel_var, FRAC_BITS));
        p1 = est_vel_var;
        k0 = kalman_gain(p0, r0);
        k1 = kalman_gain(p1, r1);
        x0 = clamp_word(x0 + scaled_product(k0, clamp_word(z0 - x0), FRAC_BITS));
        x1 = clamp_word(x1 + scaled_product(k1, clamp_word(z1 - x1), FRAC_BITS));
        p0 = clamp_variance(scaled_product(Q_ONE - k0, p0, FRAC_BITS));
        p1 = clamp_variance(scaled_product(Q_ONE - k1, p1, FRAC_BITS));
        est_pos = x0;
        est_vel = x1;
        est_pos_var = p0;
        est_vel_var = p1;
        o.estimated_position = x0[47:0];
        o.estimated_velocity = x1[47:0];
        o.estimated_position_variance = p0[46:0];
        o.estimated_velocity_variance = p1[46:0];
        return o;
    endfunction

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (estimates_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", m_data);
            end else begin
                exp_item = estimates_due.pop_front();
                if (m_data !== exp_item) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("estimate mismatch: expected %p, got %p", exp_item, m_data);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** kalman_filter_position_velocity_unit: FAILED **");
            $finish;
        end
    end

    // called and returns at a rising edge
    task automatic send_measurement(in_item_t m);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= m;
        do @(posedge aclk); while (!s_ready);
        estimates_due.push_back(filter_update(m));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (estimates_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, longint unsigned value);
        longint unsigned masked;
        drain();
        case (idx)
            REG_TIME_STEP: masked = value & 64'h1FF_FFFF;
            REG_ACCELERATION: masked = value & 64'hFFFF_FFFF;
            REG_INIT_POS_VAR, REG_INIT_VEL_VAR: masked = value & 64'h7FFF_FFFF_FFFF;
            default: masked = value & 64'hFFFF_FFFF_FFFF;
        endcase
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= masked[47:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        filt_reg[idx] = masked;
        reload_estimates();
    endtask

    function automatic longint unsigned rand_wide();
        return {$urandom, $urandom};
    endfunction

    function automatic longint rand_signed_word();
        logic signed [47:0] w;
        longint s;
        if ($urandom_range(1)) begin
            w = 48'(rand_wide());
            return w;
        end
        s = $urandom_range(1 << 24);
        return $urandom_range(1) ? s : -s;
    endfunction

    function automatic longint rand_variance();
        case ($urandom_range(5))
            0: return 0;
            1: return longint'(rand_wide() & 64'h7FFF_FFFF_FFFF);
            default: return $urandom_range(1 << 22);
        endcase
    endfunction

    function automatic in_item_t make_item(longint p, longint v, longint pv, longint vv);
        in_item_t m;
        m.measured_position = p[47:0];
        m.measured_velocity = v[47:0];
        m.measured_position_variance = pv[46:0];
        m.measured_velocity_variance = vv[46:0];
        return m;
    endfunction

    task automatic randomize_config();
        longint unsigned dt;
        case ($urandom_range(4))
            0: dt = 0;
            1: dt = 1 << 24;
            2: dt = $urandom;
            default: dt = $urandom_range(1 << 17);
        endcase
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_ACCELERATION, $urandom_range(1) ? $urandom : $urandom_range(1 << 18));
        write_reg(REG_INIT_POSITION, rand_signed_word());
        write_reg(REG_INIT_VELOCITY, rand_signed_word());
        write_reg(REG_INIT_POS_VAR, rand_variance());
        write_reg(REG_INIT_VEL_VAR, rand_variance());
    endtask

    task automatic test_field_extremes();
        send_measurement(make_item(POS_MAX, POS_MAX, VAR_MAX, VAR_MAX));
        send_measurement(make_item(POS_MIN, POS_MIN, 0, 0));
        send_measurement(make_item(0, 0, 0, 0));
        send_measurement(make_item(POS_MAX, POS_MIN, 1, VAR_MAX));
        send_measurement(make_item(POS_MIN, POS_MAX, VAR_MAX, 1));
        send_measurement(make_item(64'sd262144000, 64'sd18350080, 64'sd65536, 64'sd65536));
    endtask

    task automatic test_zero_denominator();
        write_reg(REG_INIT_POS_VAR, 0);
        write_reg(REG_INIT_VEL_VAR, 0);
        send_measurement(make_item(64'sd1000, -64'sd1000, 0, 0));
        send_measurement(make_item(POS_MAX, POS_MIN, 0, 0));
        send_measurement(make_item(64'sd5, 64'sd7, 64'sd65536, 0));
    endtask

    task automatic test_config_extremes();
        write_reg(REG_TIME_STEP, 0);
        write_reg(REG_INIT_POS_VAR, VAR_MAX);
        write_reg(REG_INIT_VEL_VAR, VAR_MAX);
        send_measurement(make_item(64'sd77, 64'sd99, 0, VAR_MAX));
        write_reg(REG_TIME_STEP, 1 << 24);
        write_reg(REG_ACCELERATION, 32'h7FFF_FFFF);
        write_reg(REG_INIT_POSITION, POS_MAX);
        write_reg(REG_INIT_VELOCITY, POS_MAX);
        send_measurement(make_item(POS_MAX, POS_MAX, 64'sd3, 64'sd3));
        send_measurement(make_item(POS_MIN, POS_MIN, 0, 0));
        write_reg(REG_ACCELERATION, 32'h8000_0000);
        write_reg(REG_INIT_POSITION, POS_MIN);
        write_reg(REG_INIT_VELOCITY, POS_MIN);
        send_measurement(make_item(POS_MIN, POS_MIN, 64'sd3, 64'sd3));
        send_measurement(make_item(POS_MAX, POS_MAX, VAR_MAX, VAR_MAX));
    endtask

    // mostly measurements that track the estimate, some wild ones
    task automatic test_random_tracking(int count, int idle_pct, int stall_pct);
        longint noise;
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) randomize_config();
            if ($urandom_range(9) < 7) begin
                noise = $urandom_range(1 << 20);
                noise = noise - (1 << 19);
                send_measurement(make_item(clamp_word(est_pos + noise),
                                           clamp_word(est_vel - noise),
                                           rand_variance(), rand_variance()));
            end else begin
                send_measurement(make_item(rand_signed_word(), rand_signed_word(),
                                           rand_variance(), rand_variance()));
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_stall = 0;
        hold_left = 400;
        for (int n = 0; n < 6; n++)
            send_measurement(make_item(rand_signed_word(), rand_signed_word(),
                                       rand_variance(), rand_variance()));
        // pause until every estimate is out, then resume
        drain();
        for (int n = 0; n < 4; n++)
            send_measurement(make_item(rand_signed_word(), rand_signed_word(),
                                       rand_variance(), rand_variance()));
        drain();
    endtask

    initial begin
        filt_reg[REG_TIME_STEP] = 65536;
        filt_reg[REG_ACCELERATION] = 131072;
        filt_reg[REG_INIT_POSITION] = 262144000;
        filt_reg[REG_INIT_VELOCITY] = 18350080;
        filt_reg[REG_INIT_POS_VAR] = 26214400;
        filt_reg[REG_INIT_VEL_VAR] = 1638400;
        reload_estimates();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_zero_denominator();
        test_config_extremes();
        test_backpressure();
        test_random_tracking(400, 0, 0);
        test_random_tracking(400, 77, 0);
        test_random_tracking(400, 0, 77);
        test_random_tracking(400, 7, 7);
        test_random_tracking(100, 0, 0);
        drain();
        if (mismatches == 0 && estimates_due.size() == 0)
            $display("** kalman_filter_position_velocity_unit: PASSED **");
        else
            $display("** kalman_filter_position_velocity_unit: FAILED **");
        $finish;
    end
endmodule

FILE: kalman_filter_position_velocity_unit.f
hdl/kfpv_pkg.sv
hdl/kfpv_mul.sv
hdl/kfpv_gain_lane.sv
hdl/kalman_filter_position_velocity_unit.sv
hdl/kfpv_checker.sv
test/kalman_filter_position_velocity_unit_tb.sv
